// ===== design/serial_keyboard_link_controller_assert.svh =====
// Assertion macros shared by the serial keyboard link controller.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SERIAL_KEYBOARD_LINK_CONTROLLER_ASSERT_SVH
`define SERIAL_KEYBOARD_LINK_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/skl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_pkg
// Types, codes and constants of the serial keyboard link controller.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int KEY_COUNT  = 128;
  localparam int KEY_W      = $clog2(KEY_COUNT);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CD_W       = 22;
  localparam int TIME_W     = 32;

  localparam int HS_MIN_W   = 10;
  localparam int ACK_W      = 18;
  localparam int ST_W       = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HS_MIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELFTEST_WAIT = 2'd2;

  localparam logic [HS_MIN_W-1:0] HS_MIN_RST        = 10'd45;
  localparam logic [ACK_W-1:0]    ACK_TIMEOUT_RST   = 18'd145000;
  localparam logic [ST_W-1:0]     SELFTEST_WAIT_RST = 21'd1000000;

  // Item kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_SP      = 2'd3;

  // Handshake verdicts.
  localparam logic [1:0] HS_NONE   = 2'd0;
  localparam logic [1:0] HS_ACCEPT = 2'd1;
  localparam logic [1:0] HS_REJECT = 2'd2;

  // Link phase codes as reported on the result channel.
  localparam logic [2:0] PH_CODE_IDLE     = 3'd0;
  localparam logic [2:0] PH_CODE_SELFTEST = 3'd1;
  localparam logic [2:0] PH_CODE_SYNC     = 3'd2;
  localparam logic [2:0] PH_CODE_STRM_ON  = 3'd3;
  localparam logic [2:0] PH_CODE_STRM_OFF = 3'd4;
  localparam logic [2:0] PH_CODE_SEND     = 3'd5;
  localparam logic [2:0] PH_CODE_WAIT     = 3'd6;

  // Link control codes and the release flag.
  localparam logic [7:0] CODE_SYNC     = 8'hFF;
  localparam logic [7:0] CODE_STRM_ON  = 8'hFD;
  localparam logic [7:0] CODE_STRM_OFF = 8'hFE;
  localparam logic [7:0] RELEASE_FLAG  = 8'h80;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_SELFTEST = 7'b0000010,
    PH_SYNC     = 7'b0000100,
    PH_STRM_ON  = 7'b0001000,
    PH_STRM_OFF = 7'b0010000,
    PH_SEND     = 7'b0100000,
    PH_WAIT     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic             sp_level;
  } in_item_t;

  typedef struct packed {
    logic              code_valid;
    logic [7:0]        line_code;
    logic [1:0]        handshake;
    logic              key_is_down;
    logic [FILL_W-1:0] fifo_count;
    logic [2:0]        link_phase;
  } out_item_t;

  typedef struct packed {
    logic [HS_MIN_W-1:0] hs_min;
    logic [ACK_W-1:0]    ack_timeout;
    logic [ST_W-1:0]     selftest_wait;
  } cfg_regs_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } fifo_ctl_t;

  typedef struct packed {
    logic tick;
    logic push;
    logic hs_accept;
  } seq_evt_t;

  typedef struct packed {
    logic       pop;
    logic       code_valid;
    logic [7:0] line_code;
    logic [2:0] phase_code;
  } seq_res_t;

  // Codes leave the block rotated left by one bit and inverted.
  function automatic logic [7:0] encode(input logic [7:0] c);
    encode = ~{c[6:0], c[7]};
  endfunction

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] r;
    case (p)
      PH_IDLE:     r = PH_CODE_IDLE;
      PH_SELFTEST: r = PH_CODE_SELFTEST;
      PH_SYNC:     r = PH_CODE_SYNC;
      PH_STRM_ON:  r = PH_CODE_STRM_ON;
      PH_STRM_OFF: r = PH_CODE_STRM_OFF;
      PH_SEND:     r = PH_CODE_SEND;
      PH_WAIT:     r = PH_CODE_WAIT;
      default:     r = PH_CODE_IDLE;
    endcase
    return r;
  endfunction

endpackage

// ===== design/skl_code_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_code_fifo
// Type-ahead queue of key codes: shift register with a fill count.
// ----------------------------------------------------------------------------
module skl_code_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  skl_pkg::fifo_ctl_t        ctl,
  output logic [skl_pkg::FILL_W-1:0] fill,
  output logic [skl_pkg::FILL_W-1:0] fill_nxt,
  output logic [7:0]                head,
  output logic                      full
);

  logic [7:0]                 mem_r [skl_pkg::FIFO_DEPTH];
  logic [skl_pkg::FILL_W-1:0] fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.push) begin
      fill_nxt = fill_r + skl_pkg::FILL_W'(1);
    end else if (ctl.pop) begin
      fill_nxt = fill_r - skl_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Entries above the fill count are never read, so the storage has no reset.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      for (int i = 0; i < skl_pkg::FIFO_DEPTH - 1; i++) begin
        mem_r[i] <= mem_r[i + 1];
      end
    end else if (ctl.push) begin
      mem_r[fill_r[skl_pkg::IDX_W-1:0]] <= ctl.data;
    end
  end

  assign fill = fill_r;
  assign head = mem_r[0];
  assign full = (fill_r == skl_pkg::FILL_W'(skl_pkg::FIFO_DEPTH));

endmodule

// ===== design/skl_sp_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_sp_monitor
// Microsecond time base and SP line edge times; judges the low pulse width.
// ----------------------------------------------------------------------------
module skl_sp_monitor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  logic                        sp_evt,
  input  logic                        sp_level,
  input  logic [skl_pkg::HS_MIN_W-1:0] hs_min,
  output logic [1:0]                  handshake,
  output logic                        hs_accept
);

  logic [skl_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [skl_pkg::TIME_W-1:0] low_r, low_nxt;
  logic [skl_pkg::TIME_W-1:0] high_r, high_nxt;
  logic [skl_pkg::TIME_W-1:0] width;
  logic                       neg;

  // True when a - b, read as a signed difference, is not positive.
  function automatic logic not_after(input logic [skl_pkg::TIME_W-1:0] a,
                                     input logic [skl_pkg::TIME_W-1:0] b);
    logic [skl_pkg::TIME_W-1:0] d;
    d = a - b;
    return (d == '0) || d[skl_pkg::TIME_W-1];
  endfunction

  always_comb begin
    now_nxt  = tick ? now_r + skl_pkg::TIME_W'(1) : now_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    if (sp_evt) begin
      if (sp_level) begin
        if (not_after(high_r, low_r)) begin
          high_nxt = now_r;
        end
      end else begin
        if (not_after(low_r, high_r)) begin
          low_nxt = now_r;
        end
      end
    end
    width     = high_nxt - low_nxt;
    neg       = width[skl_pkg::TIME_W-1];
    hs_accept = 1'b0;
    handshake = skl_pkg::HS_NONE;
    if (sp_evt && !neg) begin
      if (width >= skl_pkg::TIME_W'(hs_min)) begin
        hs_accept = 1'b1;
        handshake = skl_pkg::HS_ACCEPT;
      end else if (width != '0) begin
        handshake = skl_pkg::HS_REJECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else begin
      now_r  <= now_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

// ===== design/skl_link_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_link_seq
// Link phase sequencer: selftest, sync, stream on/off and key code sending.
// ----------------------------------------------------------------------------
module skl_link_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  skl_pkg::seq_evt_t         evt,
  input  skl_pkg::cfg_regs_t        cfg,
  input  logic [skl_pkg::FILL_W-1:0] fill,
  input  logic [7:0]                head,
  output skl_pkg::seq_res_t         res
);

  skl_pkg::phase_t          phase_r, phase_nxt;
  skl_pkg::phase_t          after_r, after_nxt;
  logic [skl_pkg::CD_W-1:0] cd_r, cd_nxt;
  logic [skl_pkg::CD_W-1:0] cd_dec;
  logic [skl_pkg::CD_W-1:0] ack_x1, ack_x8, ack_x9;

  assign ack_x1 = skl_pkg::CD_W'(cfg.ack_timeout);
  assign ack_x8 = ack_x1 << 3;
  assign ack_x9 = ack_x8 + ack_x1;
  assign cd_dec = (cd_r != '0) ? cd_r - skl_pkg::CD_W'(1) : cd_r;

  always_comb begin
    phase_nxt      = phase_r;
    after_nxt      = after_r;
    cd_nxt         = cd_r;
    res.pop        = 1'b0;
    res.code_valid = 1'b0;
    res.line_code  = 8'h00;
    if (evt.tick && phase_r != skl_pkg::PH_IDLE) begin
      cd_nxt = cd_dec;
      if (cd_dec == '0) begin
        case (phase_r)
          skl_pkg::PH_SELFTEST: begin
            phase_nxt = skl_pkg::PH_WAIT;
            after_nxt = skl_pkg::PH_STRM_ON;
            cd_nxt    = skl_pkg::CD_W'(cfg.selftest_wait);
          end
          skl_pkg::PH_SYNC: begin
            res.code_valid = 1'b1;
            res.line_code  = skl_pkg::encode(skl_pkg::CODE_SYNC);
            phase_nxt      = skl_pkg::PH_WAIT;
            after_nxt      = skl_pkg::PH_STRM_ON;
            cd_nxt         = ack_x8;
          end
          skl_pkg::PH_STRM_ON: begin
            res.code_valid = 1'b1;
            res.line_code  = skl_pkg::encode(skl_pkg::CODE_STRM_ON);
            phase_nxt      = skl_pkg::PH_WAIT;
            after_nxt      = skl_pkg::PH_STRM_OFF;
            cd_nxt         = ack_x1;
          end
          skl_pkg::PH_STRM_OFF: begin
            res.code_valid = 1'b1;
            res.line_code  = skl_pkg::encode(skl_pkg::CODE_STRM_OFF);
            phase_nxt      = skl_pkg::PH_WAIT;
            after_nxt      = skl_pkg::PH_SEND;
            cd_nxt         = ack_x1;
          end
          skl_pkg::PH_SEND: begin
            if (fill != '0) begin
              res.pop        = 1'b1;
              res.code_valid = 1'b1;
              res.line_code  = skl_pkg::encode(head);
            end
            // More than one code queued means another remains after this pop.
            if (fill > skl_pkg::FILL_W'(1)) begin
              phase_nxt = skl_pkg::PH_WAIT;
              after_nxt = skl_pkg::PH_SEND;
              cd_nxt    = ack_x9;
            end else begin
              phase_nxt = skl_pkg::PH_IDLE;
              cd_nxt    = '0;
            end
          end
          skl_pkg::PH_WAIT: begin
            phase_nxt = skl_pkg::PH_SYNC;
            cd_nxt    = '0;
          end
          default: begin
            phase_nxt = skl_pkg::PH_IDLE;
          end
        endcase
      end
    end else if (evt.push && phase_r == skl_pkg::PH_IDLE) begin
      phase_nxt = skl_pkg::PH_SEND;
      cd_nxt    = '0;
    end else if (evt.hs_accept && phase_r == skl_pkg::PH_WAIT) begin
      phase_nxt = after_r;
      cd_nxt    = '0;
    end
    res.phase_code = skl_pkg::phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= skl_pkg::PH_SELFTEST;
      after_r <= skl_pkg::PH_STRM_ON;
      cd_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      after_r <= after_nxt;
      cd_r    <= cd_nxt;
    end
  end

endmodule

// ===== design/serial_keyboard_link_controller.sv =====
`timescale 1ns / 1ps
// A request is held in the input register, then its result is written to the output register.
// One request per cycle while out_stall is low; each takes a single pass from input to result register.
// The input register can take a request while a finished result waits on the output side.
// Reset (synchronous, rst_n low): key-down bits, queue count, times and countdown clear,
// the link restarts at selftest and the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// serial_keyboard_link_controller
// Keyboard side of a handshaked serial key link with a type-ahead code queue.
// ----------------------------------------------------------------------------
`include "serial_keyboard_link_controller_assert.svh"

module serial_keyboard_link_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  skl_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output skl_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skl_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                        in_valid_r, in_valid_nxt;
  skl_pkg::in_item_t           in_item_r;
  logic                        out_valid_r, out_valid_nxt;
  skl_pkg::out_item_t          out_item_r, out_item_nxt;
  skl_pkg::cfg_regs_t          cfg_r;
  logic [skl_pkg::KEY_COUNT-1:0] keys_r, keys_nxt;

  logic                        step;
  logic                        in_take;
  logic                        press_ok;
  logic                        release_ok;
  logic [7:0]                  push_code;
  skl_pkg::fifo_ctl_t          fifo_ctl;
  skl_pkg::seq_evt_t           seq_evt;
  skl_pkg::seq_res_t           seq_res;
  logic [skl_pkg::FILL_W-1:0]  fifo_fill;
  logic [skl_pkg::FILL_W-1:0]  fifo_fill_nxt;
  logic [7:0]                  fifo_head;
  logic                        fifo_full;
  logic [1:0]                  hs_code;
  logic                        hs_accept;

  // The held request is processed whenever the result register is free or draining.
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hs_min        <= skl_pkg::HS_MIN_RST;
      cfg_r.ack_timeout   <= skl_pkg::ACK_TIMEOUT_RST;
      cfg_r.selftest_wait <= skl_pkg::SELFTEST_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        skl_pkg::CFG_HS_MIN:        cfg_r.hs_min <= cfg_data[skl_pkg::HS_MIN_W-1:0];
        skl_pkg::CFG_ACK_TIMEOUT:   cfg_r.ack_timeout <= cfg_data[skl_pkg::ACK_W-1:0];
        skl_pkg::CFG_SELFTEST_WAIT: cfg_r.selftest_wait <= cfg_data[skl_pkg::ST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Press of a down key, release of an up key, or a full queue leaves the key-down bits and the queue as they are.
  assign press_ok   = step && in_item_r.kind == skl_pkg::KIND_PRESS &&
                      !keys_r[in_item_r.key] && !fifo_full;
  assign release_ok = step && in_item_r.kind == skl_pkg::KIND_RELEASE &&
                      keys_r[in_item_r.key] && !fifo_full;
  assign push_code  = release_ok ? ({1'b0, in_item_r.key} | skl_pkg::RELEASE_FLAG)
                                 : {1'b0, in_item_r.key};

  always_comb begin
    keys_nxt = keys_r;
    if (press_ok) begin
      keys_nxt[in_item_r.key] = 1'b1;
    end else if (release_ok) begin
      keys_nxt[in_item_r.key] = 1'b0;
    end
  end

  assign seq_evt.tick      = step && in_item_r.kind == skl_pkg::KIND_TICK;
  assign seq_evt.push      = press_ok || release_ok;
  assign seq_evt.hs_accept = hs_accept;

  assign fifo_ctl.push = press_ok || release_ok;
  assign fifo_ctl.pop  = seq_res.pop;
  assign fifo_ctl.data = push_code;

  skl_code_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fifo_ctl),
    .fill     (fifo_fill),
    .fill_nxt (fifo_fill_nxt),
    .head     (fifo_head),
    .full     (fifo_full)
  );

  skl_sp_monitor u_sp (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (seq_evt.tick),
    .sp_evt    (step && in_item_r.kind == skl_pkg::KIND_SP),
    .sp_level  (in_item_r.sp_level),
    .hs_min    (cfg_r.hs_min),
    .handshake (hs_code),
    .hs_accept (hs_accept)
  );

  skl_link_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (seq_evt),
    .cfg   (cfg_r),
    .fill  (fifo_fill),
    .head  (fifo_head),
    .res   (seq_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = step || (out_valid_r && out_stall);
    out_item_nxt.code_valid  = seq_res.code_valid;
    out_item_nxt.line_code   = seq_res.line_code;
    out_item_nxt.handshake   = hs_code;
    out_item_nxt.key_is_down = keys_nxt[in_item_r.key];
    out_item_nxt.fifo_count  = fifo_fill_nxt;
    out_item_nxt.link_phase  = seq_res.phase_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      keys_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      keys_r      <= keys_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SKL_ASSERT_SAME(a_fill_bound, 1'b1, fifo_fill <= skl_pkg::FILL_W'(skl_pkg::FIFO_DEPTH), "queue count above depth")
  `SKL_ASSERT_SAME(a_code_on_tick, step && seq_res.code_valid, in_item_r.kind == skl_pkg::KIND_TICK, "code sent on a non-tick request")
  `SKL_ASSERT_SAME(a_hs_on_sp, step && hs_code != skl_pkg::HS_NONE, in_item_r.kind == skl_pkg::KIND_SP, "handshake verdict without SP request")
  `SKL_ASSERT_NEXT(a_stall_holds, in_stall, in_valid_r, "stalled request lost from input register")

endmodule
